// File: rtl/http_chunked_body_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Clocked implication macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication, held off during reset
`define HCBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hcbd assertion failed");

// next-cycle implication, held off during reset
`define HCBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hcbd assertion failed");

`endif

// File: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] TRAIL_LEN = 2'd2;

    typedef enum logic [1:0] {
        PH_SIZE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_HALT  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_body;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] body_byte;
        t_kind      kind;
    } t_out_beat;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // decode one ASCII hex digit
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: rtl/hcbd_ifs.sv
// ----------------------------------------------------------------------------
// Chunked body decoder channels
// Valid/ready channels for raw input beats and decoded result beats.
// ----------------------------------------------------------------------------
interface hcbd_in_if import hcbd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcbd_out_if import hcbd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked body byte by byte into data, done and error beats.
// ----------------------------------------------------------------------------
//  channel  dir  payload                  handshake
//  i_in     in   in_byte[8], start_body   valid/ready
//  o_out    out  body_byte[8], kind[2]    valid/ready
//
//  One input beat per cycle while the output is not stalled; each beat's result
//  is in the output register in the cycle after acceptance. The parser state is a
//  single register set updated by one decode step, so only a stalled output holds input.
//  Synchronous active-low reset clears parser state and the output valid.
//  A stalled output blocks input only while its beat is still waiting.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbd_in_if.sink           i_in,
    hcbd_out_if.source        o_out
);

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_digits_ended, n_digits_ended;
    logic                 r_last_cr, n_last_cr;
    logic [1:0]           r_skip_left, n_skip_left;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    t_phase               cur_phase;
    logic [SIZE_BITS-1:0] cur_size;
    logic                 cur_digit_seen;
    logic                 cur_digits_ended;
    logic                 cur_last_cr;
    logic [1:0]           cur_skip_left;
    logic [SIZE_BITS-1:0] size_dec;
    logic [7:0]           c;
    t_hex                 hex;
    logic                 accept;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign c   = i_in.data.in_byte;
    assign hex = hex_decode(c);

    always_comb begin
        // start flag restarts the body before this byte
        if (i_in.data.start_body) begin
            cur_phase        = PH_SIZE;
            cur_size         = '0;
            cur_digit_seen   = 1'b0;
            cur_digits_ended = 1'b0;
            cur_last_cr      = 1'b0;
            cur_skip_left    = 2'd0;
        end else begin
            cur_phase        = r_phase;
            cur_size         = r_size;
            cur_digit_seen   = r_digit_seen;
            cur_digits_ended = r_digits_ended;
            cur_last_cr      = r_last_cr;
            cur_skip_left    = r_skip_left;
        end

        size_dec       = (cur_size != '0) ? cur_size - 1'b1 : cur_size;

        n_phase        = cur_phase;
        n_size         = cur_size;
        n_digit_seen   = cur_digit_seen;
        n_digits_ended = cur_digits_ended;
        n_last_cr      = cur_last_cr;
        n_skip_left    = cur_skip_left;
        n_out_valid    = 1'b0;
        n_out.body_byte = 8'd0;
        n_out.kind      = KIND_DATA;

        case (cur_phase)
            PH_DATA: begin
                n_size = size_dec;
                if (size_dec == '0) begin
                    n_phase     = PH_TRAIL;
                    n_skip_left = TRAIL_LEN;
                end
                n_out_valid     = 1'b1;
                n_out.body_byte = c;
                n_out.kind      = KIND_DATA;
            end
            PH_TRAIL: begin
                if (cur_skip_left != 2'd0) begin
                    n_skip_left = cur_skip_left - 2'd1;
                end
                if (cur_skip_left <= 2'd1) begin
                    n_phase        = PH_SIZE;
                    n_size         = '0;
                    n_digit_seen   = 1'b0;
                    n_digits_ended = 1'b0;
                    n_last_cr      = 1'b0;
                end
            end
            PH_SIZE: begin
                if (cur_last_cr && c == CH_LF) begin
                    if (cur_size == '0) begin
                        n_phase     = PH_HALT;
                        n_out_valid = 1'b1;
                        n_out.kind  = KIND_DONE;
                    end else begin
                        n_phase   = PH_DATA;
                        n_last_cr = 1'b0;
                    end
                end else begin
                    n_last_cr = (c == CH_CR);
                    if (!cur_digits_ended) begin
                        if (!cur_digit_seen && c == CH_SPACE) begin
                            // skip leading space
                        end else if (!hex.ok) begin
                            if (!cur_digit_seen) begin
                                n_phase     = PH_HALT;
                                n_out_valid = 1'b1;
                                n_out.kind  = KIND_ERR;
                            end else begin
                                n_digits_ended = 1'b1;
                            end
                        end else if (cur_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                            // one more digit would overflow the size field
                            n_phase     = PH_HALT;
                            n_out_valid = 1'b1;
                            n_out.kind  = KIND_ERR;
                        end else begin
                            n_size       = {cur_size[SIZE_BITS-5:0], hex.value};
                            n_digit_seen = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIZE;
            r_size         <= '0;
            r_digit_seen   <= 1'b0;
            r_digits_ended <= 1'b0;
            r_last_cr      <= 1'b0;
            r_skip_left    <= 2'd0;
            r_out_valid    <= 1'b0;
        end else if (accept) begin
            r_phase        <= n_phase;
            r_size         <= n_size;
            r_digit_seen   <= n_digit_seen;
            r_digits_ended <= n_digits_ended;
            r_last_cr      <= n_last_cr;
            r_skip_left    <= n_skip_left;
            r_out_valid    <= n_out_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on the chunked body decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker
    import hcbd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_body_byte,
    input logic [1:0] i_kind
);

    // a waiting result holds its beat
    `HCBD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_body_byte))

    // a new result only follows an accepted input beat
    `HCBD_ASSERT_SAME(a_out_cause, $rose(i_out_valid), $past(i_in_valid && i_in_ready))

    // input waits only on a stalled result
    `HCBD_ASSERT_SAME(a_in_ready, !i_out_valid || i_out_ready, i_in_ready)

    // done and error beats carry a zero byte
    `HCBD_ASSERT_SAME(a_ctrl_byte, i_out_valid && i_kind != KIND_DATA, i_body_byte == 8'd0)

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_body_byte (o_out.data.body_byte),
    .i_kind      (o_out.data.kind)
);
